// ===== sv/ujse_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and character constants for the JSON string escaper.
package ujse_pkg;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [6:0] out_char;
        logic       out_last;
    } t_out_item;

    localparam logic [2:0] K_NONE = 3'd0;
    localparam logic [2:0] K_CHAR = 3'd1;
    localparam logic [2:0] K_PAIR = 3'd2;
    localparam logic [2:0] K_U1   = 3'd3;
    localparam logic [2:0] K_U2   = 3'd4;

    typedef struct packed {
        logic        last;
        logic [1:0]  qcnt;
        logic [2:0]  kind;
        logic [6:0]  ch;
        logic [15:0] val0;
        logic [15:0] val1;
    } t_job;

    localparam logic [6:0] C_QMARK  = 7'h3F;
    localparam logic [6:0] C_BSLASH = 7'h5C;
    localparam logic [6:0] C_QUOTE  = 7'h22;
    localparam logic [6:0] C_LOW_U  = 7'h75;
    localparam logic [6:0] C_LOW_N  = 7'h6E;
    localparam logic [6:0] C_LOW_T  = 7'h74;
    localparam logic [6:0] C_LOW_R  = 7'h72;
    localparam logic [6:0] C_LOW_B  = 7'h62;
    localparam logic [6:0] C_LOW_F  = 7'h66;

    localparam logic [7:0] B_QUOTE  = 8'h22;
    localparam logic [7:0] B_BSLASH = 8'h5C;
    localparam logic [7:0] B_LF     = 8'h0A;
    localparam logic [7:0] B_TAB    = 8'h09;
    localparam logic [7:0] B_CR     = 8'h0D;
    localparam logic [7:0] B_BS     = 8'h08;
    localparam logic [7:0] B_FF     = 8'h0C;
    localparam logic [7:0] B_SPACE  = 8'h20;

    localparam logic [20:0] PLANE1_BASE = 21'h10000;
    localparam logic [15:0] SUR_HI_BASE = 16'hD800;
    localparam logic [15:0] SUR_LO_BASE = 16'hDC00;

    function automatic logic [6:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) begin
            hex_char = 7'h30 + {3'b000, n};
        end else begin
            hex_char = 7'h57 + {3'b000, n};
        end
    endfunction

endpackage

// ===== sv/ujse_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks the pending UTF-8 sequence, builds escape jobs.
module ujse_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  ujse_pkg::t_in_item i_item,
    output logic               o_push,
    output ujse_pkg::t_job     o_job
);
    import ujse_pkg::*;

    logic [7:0]  r_pend [3];
    logic [1:0]  r_cnt, n_cnt;
    logic [2:0]  r_exp, n_exp;
    logic [7:0]  b;
    logic        last;
    logic [2:0]  f_kind;
    logic [6:0]  f_ch;
    logic [2:0]  f_len;
    logic [20:0] cp;
    logic [20:0] sv;
    logic        wr_lead, wr_cont;
    t_job        job;

    assign b    = i_item.in_byte;
    assign last = i_item.in_last;

    always_comb begin
        f_kind = K_CHAR;
        f_ch   = b[6:0];
        f_len  = 3'd0;
        if (!b[7]) begin
            unique case (b)
                B_QUOTE: begin
                    f_kind = K_PAIR;
                    f_ch   = C_QUOTE;
                end
                B_BSLASH: begin
                    f_kind = K_PAIR;
                    f_ch   = C_BSLASH;
                end
                B_LF: begin
                    f_kind = K_PAIR;
                    f_ch   = C_LOW_N;
                end
                B_TAB: begin
                    f_kind = K_PAIR;
                    f_ch   = C_LOW_T;
                end
                B_CR: begin
                    f_kind = K_PAIR;
                    f_ch   = C_LOW_R;
                end
                B_BS: begin
                    f_kind = K_PAIR;
                    f_ch   = C_LOW_B;
                end
                B_FF: begin
                    f_kind = K_PAIR;
                    f_ch   = C_LOW_F;
                end
                default: begin
                    if (b < B_SPACE) begin
                        f_kind = K_U1;
                    end
                end
            endcase
        end else begin
            f_ch = C_QMARK;
            if (b[7:5] == 3'b110) begin
                f_len = 3'd2;
            end else if (b[7:4] == 4'b1110) begin
                f_len = 3'd3;
            end else if (b[7:3] == 5'b11110) begin
                f_len = 3'd4;
            end
            if (f_len != 3'd0 && !last) begin
                f_kind = K_NONE;
            end
        end
    end

    always_comb begin
        unique case (r_exp)
            3'd2:    cp = {10'd0, r_pend[0][4:0], b[5:0]};
            3'd3:    cp = {5'd0, r_pend[0][3:0], r_pend[1][5:0], b[5:0]};
            default: cp = {r_pend[0][2:0], r_pend[1][5:0], r_pend[2][5:0], b[5:0]};
        endcase
    end

    assign sv = cp - PLANE1_BASE;

    always_comb begin
        n_cnt     = r_cnt;
        n_exp     = r_exp;
        wr_lead   = 1'b0;
        wr_cont   = 1'b0;
        job.last  = last;
        job.qcnt  = 2'd0;
        job.kind  = f_kind;
        job.ch    = f_ch;
        job.val0  = {8'h00, b};
        job.val1  = SUR_LO_BASE | {6'd0, sv[9:0]};
        if (r_cnt != 2'd0 && b[7:6] == 2'b10) begin
            job.kind = K_NONE;
            if ({1'b0, r_cnt} + 3'd1 == r_exp) begin
                n_cnt = 2'd0;
                n_exp = 3'd0;
                if (cp[20:16] != 5'd0) begin
                    job.kind = K_U2;
                    job.val0 = SUR_HI_BASE | {5'd0, sv[20:10]};
                end else begin
                    job.kind = K_U1;
                    job.val0 = cp[15:0];
                end
            end else begin
                wr_cont = 1'b1;
                n_cnt   = r_cnt + 2'd1;
                if (last) begin
                    job.qcnt = r_cnt + 2'd1;
                end
            end
        end else begin
            job.qcnt = r_cnt;
            n_cnt    = 2'd0;
            n_exp    = 3'd0;
            if (f_kind == K_NONE) begin
                wr_lead = 1'b1;
                n_cnt   = 2'd1;
                n_exp   = f_len;
            end
        end
        if (last) begin
            n_cnt = 2'd0;
            n_exp = 3'd0;
        end
    end

    assign o_job  = job;
    assign o_push = i_accept && (job.qcnt != 2'd0 || job.kind != K_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_exp <= 3'd0;
        end else if (i_accept) begin
            r_cnt <= n_cnt;
            r_exp <= n_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && wr_lead) begin
            r_pend[0] <= b;
        end
        if (i_accept && wr_cont) begin
            r_pend[r_cnt] <= b;
        end
    end

endmodule

// ===== sv/ujse_queue.sv =====
`timescale 1ns / 1ps
// Job queue between front end and back end.
module ujse_queue #(
    parameter int DEPTH = ujse_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ujse_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output ujse_pkg::t_job o_job
);
    import ujse_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ===== sv/ujse_back.sv =====
`timescale 1ns / 1ps
// Back end: expands one job into escaped characters, one item per cycle while the output is not stalled.
module ujse_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_qvalid,
    input  ujse_pkg::t_job      i_job,
    output logic                o_pop,
    output logic                o_valid,
    output ujse_pkg::t_out_item o_item,
    input  logic                i_stall
);
    import ujse_pkg::*;

    logic [3:0]  r_pos;
    logic        r_valid;
    t_out_item   r_item;
    logic [3:0]  mlen, total, m, j;
    logic        second, at_end, load;
    logic [15:0] v;
    logic [6:0]  ch;

    always_comb begin
        unique case (i_job.kind)
            K_CHAR:  mlen = 4'd1;
            K_PAIR:  mlen = 4'd2;
            K_U1:    mlen = 4'd6;
            K_U2:    mlen = 4'd12;
            default: mlen = 4'd0;
        endcase
    end

    assign total  = {2'b00, i_job.qcnt} + mlen;
    assign at_end = (r_pos == total - 4'd1);
    assign m      = r_pos - {2'b00, i_job.qcnt};
    assign second = (m >= 4'd6);
    assign j      = second ? m - 4'd6 : m;
    assign v      = second ? i_job.val1 : i_job.val0;

    always_comb begin
        ch = C_QMARK;
        if (r_pos >= {2'b00, i_job.qcnt}) begin
            unique case (i_job.kind)
                K_CHAR: ch = i_job.ch;
                K_PAIR: ch = (m == 4'd0) ? C_BSLASH : i_job.ch;
                K_U1, K_U2: begin
                    unique case (j[2:0])
                        3'd0:    ch = C_BSLASH;
                        3'd1:    ch = C_LOW_U;
                        3'd2:    ch = hex_char(v[15:12]);
                        3'd3:    ch = hex_char(v[11:8]);
                        3'd4:    ch = hex_char(v[7:4]);
                        3'd5:    ch = hex_char(v[3:0]);
                        default: ch = C_QMARK;
                    endcase
                end
                default: ch = C_QMARK;
            endcase
        end
    end

    assign load    = i_qvalid && (!r_valid || !i_stall);
    assign o_pop   = load && at_end;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 4'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_pos   <= at_end ? 4'd0 : r_pos + 4'd1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.out_char <= ch;
            r_item.out_last <= i_job.last && at_end;
        end
    end

endmodule

// ===== sv/utf8_json_string_escaper_unit.sv =====
`timescale 1ns / 1ps
// Top level of the JSON string escaper with UTF-8 to UTF-16 escape conversion.
// The first character of an item passes through the job queue and then leaves the output register.
// Throughput: one input item per cycle while the job queue has room; one character per cycle out while not stalled.
// An item expands to 0 to 12 characters; the output register's single character port sets the rate.
// Input stalls while QDEPTH jobs wait in the queue.
// Synchronous active-low reset empties the queue and output register and drops any pending sequence.
module utf8_json_string_escaper_unit #(
    parameter int QDEPTH = ujse_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ujse_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output ujse_pkg::t_out_item o_item
);
    import ujse_pkg::*;

    logic accept, push, full, qvalid, pop;
    t_job push_job, head_job;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    ujse_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (push),
        .o_job    (push_job)
    );

    ujse_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (qvalid),
        .o_job   (head_job)
    );

    ujse_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_qvalid (qvalid),
        .i_job    (head_job),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_item   (o_item),
        .i_stall  (i_stall)
    );

endmodule

// ===== sv/ujse_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the escaper, bound to the top level.
module ujse_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input ujse_pkg::t_in_item  i_item,
    input logic                o_valid,
    input logic                i_stall,
    input ujse_pkg::t_out_item o_item
);
    import ujse_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_valid && i_stall) |-> o_valid && $stable(o_item))
        else $error("output item changed while stalled");

    a_reset_out: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

    a_reset_in: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_stall)
        else $error("input stalled right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(o_stall) |-> $past(i_valid && !o_stall))
        else $error("input stall rose without an accepted item");

endmodule

bind utf8_json_string_escaper_unit ujse_checker u_chk (.*);
